@@ rtl/ppl_pkg.sv @@
// Shared constants, types and codes for the packed pixel layer compositor.
`timescale 1ns / 1ps

package ppl_pkg;

  // Screen geometry
  localparam int PAL_WIDTH     = 384;
  localparam int PAL_HEIGHT    = 288;
  localparam int NTSC_WIDTH    = 320;
  localparam int SCREEN_PIXELS = PAL_WIDTH * PAL_HEIGHT;
  localparam int SCREEN_WORDS  = (SCREEN_PIXELS + 7) / 8;
  localparam int STORE_DEPTH   = 2 * SCREEN_WORDS;

  // Widths
  localparam int WORD_W  = 16;
  localparam int COORD_W = 11;
  localparam int COLOR_W = 2;
  localparam int PIX_W   = $clog2(SCREEN_PIXELS);
  localparam int WIDX_W  = $clog2(SCREEN_WORDS);
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int SUB_W   = 3;
  localparam int MATH_W  = 24;

  typedef logic [ADDR_W-1:0] ram_addr_t;
  typedef logic [WORD_W-1:0] word_t;

  // Item kinds
  localparam logic KIND_SET     = 1'b0;
  localparam logic KIND_COMPOSE = 1'b1;

  // Layer select for set items
  localparam logic LAYER_MAIN    = 1'b0;
  localparam logic LAYER_OVERLAY = 1'b1;

  // Color code that a set item drops
  localparam logic [COLOR_W-1:0] COLOR_IGNORED = 2'd1;

  // Configuration register indexes
  localparam logic REG_SCREEN0_NTSC = 1'b0;
  localparam logic REG_SCREEN1_NTSC = 1'b1;

  // Mapped request as handed from the address mapper to the control
  typedef struct packed {
    logic                ok;
    ram_addr_t           addr;
    logic [WIDX_W-1:0]   widx;
    logic [SUB_W-1:0]    sub;
  } map_t;

endpackage

@@ rtl/packed_pixel_layer_compositor.sv @@
// Top level: two-screen 2-bit packed layer compositor with read-modify-write stores.
// done is registered from the write-back state (ST_RMW) that the accepting edge enters.
// The single-port stores are read at the accept edge and written back from ST_RMW, so
// busy stays high during write-back and a new request is not taken until it is done.
// Reset (rst, synchronous) clears NTSC registers and runs a clearing pass over all
// 27648 addresses (one word of all three stores per cycle) with busy high.
`timescale 1ns / 1ps

module packed_pixel_layer_compositor
  import ppl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind,
  input  logic                      screen,
  input  logic                      layer,
  input  logic                      vertical,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic [COLOR_W-1:0]        color,
  output logic                      done,
  output logic                      accepted,
  output logic [WIDX_W-1:0]         word_index,
  output logic [WORD_W-1:0]         word_value,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic                      cfg_data
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RMW   = 3'b100
  } state_t;

  state_t state, state_next;

  logic              screen0_is_ntsc, screen1_is_ntsc;
  ram_addr_t         clear_cnt;
  logic              take;
  map_t              map;

  // Request held across the read cycle
  map_t              op_map;
  logic              op_kind, op_layer;
  logic [COLOR_W-1:0] op_color;

  word_t             main_q, ovl_q, frm_q;
  word_t             mask, src, new_word;
  logic [3:0]        shift;
  ram_addr_t         ram_addr;
  logic              main_we, ovl_we, frm_we;
  word_t             main_wd, ovl_wd, frm_wd;

  assign busy      = (state != ST_IDLE);
  assign take      = start && !busy;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen0_is_ntsc <= 1'b0;
      screen1_is_ntsc <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN0_NTSC: screen0_is_ntsc <= cfg_data;
        REG_SCREEN1_NTSC: screen1_is_ntsc <= cfg_data;
        default: ;
      endcase
    end
  end

  ppl_map u_map (
    .kind     (kind),
    .screen   (screen),
    .vertical (vertical),
    .ntsc     (screen ? screen1_is_ntsc : screen0_is_ntsc),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .color    (color),
    .map      (map)
  );

  // Control sequencing
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clear_cnt == ram_addr_t'(STORE_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (take) state_next = ST_RMW;
      ST_RMW:   state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clear_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_cnt <= clear_cnt + 1'b1;
      end
    end
  end

  // Capture the mapped request at accept
  always_ff @(posedge clk) begin
    if (take) begin
      op_map   <= map;
      op_kind  <= kind;
      op_layer <= layer;
      op_color <= color;
    end
  end

  // Modify: first pixel of a word sits in the top bits
  always_comb begin
    shift = {~op_map.sub, 1'b0};
    mask  = word_t'(2'b11) << shift;
    src   = ovl_q[shift + 4'd1] ? ovl_q : main_q;
    if (op_kind == KIND_SET) begin
      new_word = ((op_layer == LAYER_OVERLAY ? ovl_q : main_q) & ~mask)
               | (word_t'(op_color) << shift);
    end else begin
      new_word = (frm_q & ~mask) | (src & mask);
    end
  end

  // Store port steering: clear sweep, read at accept, write-back
  always_comb begin
    main_we = 1'b0;
    ovl_we  = 1'b0;
    frm_we  = 1'b0;
    main_wd = new_word;
    ovl_wd  = new_word;
    frm_wd  = new_word;
    ram_addr = map.addr;
    case (state)
      ST_CLEAR: begin
        ram_addr = clear_cnt;
        main_we  = 1'b1;
        ovl_we   = 1'b1;
        frm_we   = 1'b1;
        main_wd  = '0;
        ovl_wd   = '0;
        frm_wd   = '0;
      end
      ST_RMW: begin
        ram_addr = op_map.addr;
        if (op_map.ok) begin
          main_we = (op_kind == KIND_SET) && (op_layer == LAYER_MAIN);
          ovl_we  = (op_kind == KIND_SET) && (op_layer == LAYER_OVERLAY);
          frm_we  = (op_kind == KIND_COMPOSE);
        end
      end
      default: ;
    endcase
  end

  ppl_ram u_main (
    .clk(clk), .we(main_we), .addr(ram_addr), .wdata(main_wd), .rdata(main_q)
  );

  ppl_ram u_ovl (
    .clk(clk), .we(ovl_we), .addr(ram_addr), .wdata(ovl_wd), .rdata(ovl_q)
  );

  ppl_ram u_frm (
    .clk(clk), .we(frm_we), .addr(ram_addr), .wdata(frm_wd), .rdata(frm_q)
  );

  // Result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      accepted <= 1'b0;
    end else begin
      done     <= (state == ST_RMW);
      accepted <= (state == ST_RMW) && op_map.ok;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RMW) begin
      word_index <= op_map.ok ? op_map.widx : '0;
      word_value <= op_map.ok ? new_word : '0;
    end
  end

  // Checks
  a_done_after_rmw: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_RMW))
    else $error("done without a write-back cycle");

  a_take_to_rmw: assert property (@(posedge clk) disable iff (rst)
    take |=> (state == ST_RMW) && busy)
    else $error("accepted request did not enter write-back");

  a_acc_with_done: assert property (@(posedge clk) disable iff (rst)
    accepted |-> done)
    else $error("accepted flag outside a result cycle");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !(main_we || ovl_we || frm_we))
    else $error("store written while idle");

endmodule

@@ rtl/ppl_ram.sv @@
// Single-port word store with registered read.
`timescale 1ns / 1ps

module ppl_ram
  import ppl_pkg::*;
(
  input  logic      clk,
  input  logic      we,
  input  ram_addr_t addr,
  input  word_t     wdata,
  output word_t     rdata
);

  word_t mem [STORE_DEPTH];

  // Read-first port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/ppl_map.sv @@
// Coordinate range check and pixel-to-word address mapping.
`timescale 1ns / 1ps

module ppl_map
  import ppl_pkg::*;
(
  input  logic                      kind,
  input  logic                      screen,
  input  logic                      vertical,
  input  logic                      ntsc,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic [COLOR_W-1:0]        color,
  output map_t                      map
);

  localparam logic signed [MATH_W-1:0] PW_S  = MATH_W'(PAL_WIDTH);
  localparam logic signed [MATH_W-1:0] PH_S  = MATH_W'(PAL_HEIGHT);
  localparam logic signed [MATH_W-1:0] NW_S  = MATH_W'(NTSC_WIDTH);
  localparam logic signed [MATH_W-1:0] SP_S  = MATH_W'(SCREEN_PIXELS);
  localparam logic signed [MATH_W-1:0] ONE_S = MATH_W'(1);

  logic signed [MATH_W-1:0] xs, ys, w_s, p_h, p_v, p;
  logic                     in_h, in_v, in_rng, drop;
  logic [PIX_W-1:0]         p_u;

  always_comb begin
    xs  = MATH_W'(pos_x);
    ys  = MATH_W'(pos_y);
    w_s = ntsc ? NW_S : PW_S;

    // Horizontal: row-major; vertical: rotated, may crop on NTSC
    in_h = (xs >= 0) && (xs < PW_S) && (ys >= 0) && (ys < PH_S);
    in_v = (xs >= 0) && (xs < PH_S) && (ys >= 0) && (ys < PW_S);
    p_h  = ys * PW_S + xs;
    p_v  = xs * PW_S + w_s - ONE_S - ys;

    p      = vertical ? p_v : p_h;
    in_rng = (vertical ? in_v : in_h) && (p >= 0) && (p < SP_S);
    drop   = (kind == KIND_SET) && (color == COLOR_IGNORED);
    p_u    = p[PIX_W-1:0];

    map.ok   = in_rng && !drop;
    map.widx = p_u[PIX_W-1:SUB_W];
    map.sub  = p_u[SUB_W-1:0];
    map.addr = screen ? ADDR_W'(map.widx) + ADDR_W'(SCREEN_WORDS) : ADDR_W'(map.widx);
  end

endmodule
